>>> hw/rtl/wsdf_pkg.sv
// Package for the WebSocket frame deframer: parse phases, result kinds,
// opcodes, result and counter structs and the opcode-to-kind function.
// Depends on nothing; every other file of the block uses it.
package wsdf_pkg;

	localparam int RX_BYTE_W   = 8;
	localparam int KIND_W      = 3;
	localparam int CNT_W       = 32;
	localparam int MAX_LEN_W   = 31;
	localparam int LEN_W       = 64;
	localparam int KEY_W       = 32;
	localparam int PHASE_W     = 3;
	localparam int OPCODE_W    = 4;
	localparam int HDR_CNT_W   = 3;
	localparam int HDR_SIZE_W  = 4;

	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = '1;

	// parse phases
	localparam logic [PHASE_W-1:0] PH_HDR0    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HDR1    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_EXTLEN  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_MASK    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_TEXT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BINARY = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PING   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PONG   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_NONE   = 3'd7;

	// frame opcodes
	localparam logic [OPCODE_W-1:0] OP_TEXT   = 4'h1;
	localparam logic [OPCODE_W-1:0] OP_BINARY = 4'h2;
	localparam logic [OPCODE_W-1:0] OP_CLOSE  = 4'h8;
	localparam logic [OPCODE_W-1:0] OP_PING   = 4'h9;
	localparam logic [OPCODE_W-1:0] OP_PONG   = 4'hA;

	// second header byte: mask flag and length codes
	localparam int                MASK_BIT  = 7;
	localparam logic [6:0]        LEN_CODE_16 = 7'd126;
	localparam logic [6:0]        LEN_CODE_64 = 7'd127;
	localparam logic [HDR_SIZE_W-1:0] HDR_SIZE_SHORT = 4'd2;
	localparam logic [HDR_SIZE_W-1:0] HDR_SIZE_16    = 4'd4;
	localparam logic [HDR_SIZE_W-1:0] HDR_SIZE_64    = 4'd10;
	localparam logic [HDR_SIZE_W-1:0] MASK_SIZE      = 4'd4;
	localparam logic [HDR_CNT_W-1:0]  EXT16_BYTES_M1 = 3'd1;
	localparam logic [HDR_CNT_W-1:0]  EXT64_BYTES_M1 = 3'd7;
	localparam logic [HDR_CNT_W-1:0]  MASK_BYTES_M1  = 3'd3;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [RX_BYTE_W-1:0] payload_byte;
		logic                 has_data;
		logic                 frame_end;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0] frames;
		logic [CNT_W-1:0] messages;
		logic [CNT_W-1:0] data_bytes;
		logic [CNT_W-1:0] pongs;
	} cnt_t;

	function automatic logic [KIND_W-1:0] kind_of(input logic [OPCODE_W-1:0] op);
		logic [KIND_W-1:0] k;
		case (op)
			OP_TEXT:   k = KIND_TEXT;
			OP_BINARY: k = KIND_BINARY;
			OP_CLOSE:  k = KIND_CLOSE;
			OP_PING:   k = KIND_PING;
			OP_PONG:   k = KIND_PONG;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

>>> hw/rtl/wsdf_ifs.sv
// Channel interfaces of the WebSocket frame deframer: received bytes,
// results with counters, and the frame size limit write channel.
// Depends on wsdf_pkg for the field widths.
interface wsdf_rx_if;
	logic                          valid;
	logic                          ready;
	logic [wsdf_pkg::RX_BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdf_res_if;
	logic                           valid;
	logic                           ready;
	logic [wsdf_pkg::KIND_W-1:0]    kind;
	logic [wsdf_pkg::RX_BYTE_W-1:0] payload_byte;
	logic                           has_data;
	logic                           frame_end;
	logic [wsdf_pkg::CNT_W-1:0]     frames_received;
	logic [wsdf_pkg::CNT_W-1:0]     messages_received;
	logic [wsdf_pkg::CNT_W-1:0]     data_bytes_received;
	logic [wsdf_pkg::CNT_W-1:0]     pongs_received;
	modport source (output valid, output kind, output payload_byte, output has_data,
		output frame_end, output frames_received, output messages_received,
		output data_bytes_received, output pongs_received, input ready);
	modport sink (input valid, input kind, input payload_byte, input has_data,
		input frame_end, input frames_received, input messages_received,
		input data_bytes_received, input pongs_received, output ready);
endinterface

interface wsdf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wsdf_pkg::MAX_LEN_W-1:0] max_frame_len;
	modport source (output valid, output max_frame_len, input ready);
	modport sink (input valid, input max_frame_len, output ready);
endinterface

>>> hw/rtl/wsdf_in_stage.sv
// Input register of the deframer: holds one received byte until the parser
// takes it. Depends on wsdf_pkg.
module wsdf_in_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wsdf_pkg::RX_BYTE_W-1:0] in_byte,
	input  logic                           take,
	output logic                           valid_s1,
	output logic [wsdf_pkg::RX_BYTE_W-1:0] byte_s1
);
	import wsdf_pkg::*;

	// A new byte may enter in the same cycle as the held one moves on.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

>>> hw/rtl/wsdf_parser.sv
// Frame parser of the deframer: header, extended length, mask key and
// payload phases, size check, unmasking, counters and the size limit.
// Depends on wsdf_pkg.
module wsdf_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [wsdf_pkg::RX_BYTE_W-1:0] rx_byte,
	input  logic                           cfg_we,
	input  logic [wsdf_pkg::MAX_LEN_W-1:0] cfg_data,
	output logic                           res_valid,
	output wsdf_pkg::res_t                 res,
	output wsdf_pkg::cnt_t                 cnt
);
	import wsdf_pkg::*;

	logic [MAX_LEN_W-1:0]  max_len_q;
	logic [PHASE_W-1:0]    phase_q, phase_n;
	logic [OPCODE_W-1:0]   opcode_q, opcode_n;
	logic                  mask_q, mask_n;
	logic [LEN_W-1:0]      len_q, len_n;
	logic [HDR_CNT_W-1:0]  hcnt_q, hcnt_n;
	logic [HDR_SIZE_W-1:0] hsize_q, hsize_n;
	logic [KEY_W-1:0]      key_q, key_n;
	logic [MAX_LEN_W-1:0]  rem_q, rem_n;
	logic [1:0]            kidx_q, kidx_n;
	logic                  closed_q, closed_n;
	cnt_t                  cnt_q, cnt_n;

	logic                  do_len, do_start, do_done;
	logic [LEN_W-1:0]      len_val;
	logic [HDR_SIZE_W-1:0] need;
	logic [MAX_LEN_W:0]    total;
	logic                  over;
	logic [KIND_W-1:0]     k;
	logic [RX_BYTE_W-1:0]  key_byte;
	logic                  last;

	assign k = kind_of(opcode_q);

	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n   = phase_q;
		opcode_n  = opcode_q;
		mask_n    = mask_q;
		len_n     = len_q;
		hcnt_n    = hcnt_q;
		hsize_n   = hsize_q;
		key_n     = key_q;
		rem_n     = rem_q;
		kidx_n    = kidx_q;
		closed_n  = closed_q;
		cnt_n     = cnt_q;
		res_valid = 1'b0;
		res       = '0;
		do_len    = 1'b0;
		do_start  = 1'b0;
		do_done   = 1'b0;
		len_val   = len_q;
		need      = hsize_q;
		total     = '0;
		over      = 1'b0;
		last      = 1'b0;

		if (fire && !closed_q) begin
			case (phase_q)
				PH_HDR0: begin
					opcode_n = rx_byte[OPCODE_W-1:0];
					phase_n  = PH_HDR1;
				end
				PH_HDR1: begin
					mask_n = rx_byte[MASK_BIT];
					if (rx_byte[6:0] == LEN_CODE_16) begin
						hsize_n = HDR_SIZE_16;
						len_n   = '0;
						hcnt_n  = EXT16_BYTES_M1;
						phase_n = PH_EXTLEN;
					end else if (rx_byte[6:0] == LEN_CODE_64) begin
						hsize_n = HDR_SIZE_64;
						len_n   = '0;
						hcnt_n  = EXT64_BYTES_M1;
						phase_n = PH_EXTLEN;
					end else begin
						hsize_n = HDR_SIZE_SHORT;
						len_val = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
						len_n   = len_val;
						need    = HDR_SIZE_SHORT;
						do_len  = 1'b1;
					end
				end
				PH_EXTLEN: begin
					len_val = {len_q[LEN_W-RX_BYTE_W-1:0], rx_byte};
					len_n   = len_val;
					if (hcnt_q == '0) begin
						do_len = 1'b1;
					end else begin
						hcnt_n = hcnt_q - 1'b1;
					end
				end
				PH_MASK: begin
					key_n = {key_q[KEY_W-RX_BYTE_W-1:0], rx_byte};
					if (hcnt_q == '0) begin
						do_start = 1'b1;
					end else begin
						hcnt_n = hcnt_q - 1'b1;
					end
				end
				PH_PAYLOAD: begin
					kidx_n = kidx_q + 1'b1;
					rem_n  = rem_q - 1'b1;
					last   = (rem_n == '0);
					if (last) begin
						do_done = 1'b1;
					end
					if (k == KIND_CLOSE) begin
						res_valid = last;
						res.kind      = KIND_CLOSE;
						res.frame_end = 1'b1;
					end else if (k != KIND_NONE) begin
						res_valid        = 1'b1;
						res.kind         = k;
						res.payload_byte = mask_q ? (rx_byte ^ key_byte) : rx_byte;
						res.has_data     = 1'b1;
						res.frame_end    = last;
					end
				end
				default: begin
					phase_n = PH_HDR0;
				end
			endcase

			// Length known: the frame must fit header, key and payload in the limit.
			if (do_len) begin
				if (mask_n) begin
					need = need + MASK_SIZE;
				end
				total = {1'b0, len_val[MAX_LEN_W-1:0]} + {{(MAX_LEN_W+1-HDR_SIZE_W){1'b0}}, need};
				over  = (|len_val[LEN_W-1:MAX_LEN_W]) || (total > {1'b0, max_len_q});
				if (over) begin
					phase_n       = PH_HDR0;
					res_valid     = 1'b1;
					res.kind      = KIND_ERROR;
					res.frame_end = 1'b1;
				end else if (mask_n) begin
					hcnt_n  = MASK_BYTES_M1;
					key_n   = '0;
					phase_n = PH_MASK;
				end else begin
					do_start = 1'b1;
				end
			end

			if (do_start) begin
				if (len_val == '0) begin
					do_done = 1'b1;
					if (k != KIND_NONE) begin
						res_valid     = 1'b1;
						res.kind      = k;
						res.frame_end = 1'b1;
					end
				end else begin
					rem_n   = len_val[MAX_LEN_W-1:0];
					kidx_n  = '0;
					phase_n = PH_PAYLOAD;
				end
			end

			if (do_done) begin
				cnt_n.frames = cnt_q.frames + 1'b1;
				if (k == KIND_TEXT || k == KIND_BINARY) begin
					cnt_n.messages   = cnt_q.messages + 1'b1;
					cnt_n.data_bytes = cnt_q.data_bytes + len_val[CNT_W-1:0];
				end else if (k == KIND_PONG) begin
					cnt_n.pongs = cnt_q.pongs + 1'b1;
				end else if (k == KIND_CLOSE) begin
					closed_n = 1'b1;
				end
				phase_n = PH_HDR0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
			phase_q   <= PH_HDR0;
			opcode_q  <= '0;
			mask_q    <= 1'b0;
			len_q     <= '0;
			hcnt_q    <= '0;
			hsize_q   <= HDR_SIZE_SHORT;
			key_q     <= '0;
			rem_q     <= '0;
			kidx_q    <= '0;
			closed_q  <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_data;
			end
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			mask_q   <= mask_n;
			len_q    <= len_n;
			hcnt_q   <= hcnt_n;
			hsize_q  <= hsize_n;
			key_q    <= key_n;
			rem_q    <= rem_n;
			kidx_q   <= kidx_n;
			closed_q <= closed_n;
			cnt_q    <= cnt_n;
		end
	end

	assign cnt = cnt_q;

	// Once a close frame has finished, nothing but reset reopens the stream.
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed flag dropped");

	// A payload phase always has at least one byte still to come.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q != '0))
		else $error("payload phase with nothing remaining");

	a_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MASK) |-> (hcnt_q <= MASK_BYTES_M1))
		else $error("mask key byte count out of range");

	// Counters only move on a byte that is actually parsed.
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && !closed_q) |=> $stable(cnt_q))
		else $error("counters changed without a parsed byte");

endmodule

>>> hw/rtl/wsdf_out_stage.sv
// Result register of the deframer: holds one result until it is taken and
// presents it with the current counter values. Depends on wsdf_pkg.
module wsdf_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  wsdf_pkg::res_t res_in,
	input  wsdf_pkg::cnt_t cnt,
	input  logic           out_ready,
	output logic           out_valid,
	output logic           free,
	output wsdf_pkg::res_t res_out,
	output logic [wsdf_pkg::CNT_W-1:0] frames_received,
	output logic [wsdf_pkg::CNT_W-1:0] messages_received,
	output logic [wsdf_pkg::CNT_W-1:0] data_bytes_received,
	output logic [wsdf_pkg::CNT_W-1:0] pongs_received
);
	import wsdf_pkg::*;

	logic  valid_q;
	res_t  res_q;

	// The register can take a new result when empty or being emptied now.
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

	// Counters only change when the parser moves, which needs this register
	// free, so they stay matched to the held result.
	assign out_valid           = valid_q;
	assign res_out             = res_q;
	assign frames_received     = cnt.frames;
	assign messages_received   = cnt.messages;
	assign data_bytes_received = cnt.data_bytes;
	assign pongs_received      = cnt.pongs;

endmodule

>>> hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer, receive side: one received byte per cycle in,
// at most one result per byte out. Each byte sits in an input register, is
// parsed by the frame parser in one pass, and any result lands in a result
// register as the byte leaves the input register. A new byte is taken every
// cycle; the input side stalls only while the result register holds a result
// that has not been taken and the input register is occupied. The frame size
// limit is written over the config channel, which is always ready. After a
// close frame the block swallows all bytes until reset.
// Depends on wsdf_pkg, the channel interfaces and the three stage modules.
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	wsdf_rx_if.sink     rx,
	wsdf_res_if.source  res,
	wsdf_cfg_if.sink    cfg
);
	import wsdf_pkg::*;

	logic                  valid_s1;
	logic [RX_BYTE_W-1:0]  byte_s1;
	logic                  out_free;
	logic                  advance;
	logic                  p_valid;
	res_t                  p_res;
	res_t                  r_res;
	cnt_t                  cnt;

	assign advance   = valid_s1 && out_free;
	assign cfg.ready = 1'b1;

	wsdf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_byte  (rx.rx_byte),
		.take     (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsdf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.rx_byte   (byte_s1),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.max_frame_len),
		.res_valid (p_valid),
		.res       (p_res),
		.cnt       (cnt)
	);

	wsdf_out_stage u_out (
		.clk                 (clk),
		.arst_n              (arst_n),
		.load                (advance && p_valid),
		.res_in              (p_res),
		.cnt                 (cnt),
		.out_ready           (res.ready),
		.out_valid           (res.valid),
		.free                (out_free),
		.res_out             (r_res),
		.frames_received     (res.frames_received),
		.messages_received   (res.messages_received),
		.data_bytes_received (res.data_bytes_received),
		.pongs_received      (res.pongs_received)
	);

	assign res.kind         = r_res.kind;
	assign res.payload_byte = r_res.payload_byte;
	assign res.has_data     = r_res.has_data;
	assign res.frame_end    = r_res.frame_end;

endmodule
